### sv/ipv4f_pkg.sv
package ipv4f_pkg;

    localparam int RULE_SLOTS_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_QUARANTINE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HUB_ADDR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUB_PORT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DHCP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DNS        = 3'd4;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_RULE  = 1'b1;

    localparam logic [1:0] ACT_EMPTY = 2'd0;
    localparam logic [1:0] ACT_BLOCK = 2'd1;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  LOOPBACK_NET  = 8'd127;
    localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
    localparam logic [15:0] PORT_DHCP_CLI = 16'd68;
    localparam logic [15:0] PORT_DNS      = 16'd53;
    localparam logic [7:0]  MIN_FRAME_LEN = 8'd34;
    localparam logic [7:0]  ETH_HDR_LEN   = 8'd14;
    localparam logic [7:0]  TCP_HDR_LEN   = 8'd20;
    localparam logic [7:0]  UDP_HDR_LEN   = 8'd8;
    localparam logic [7:0]  COUNT_MAX     = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_PUSH
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic latch_verdict;
        logic search_start;
        logic search_next;
        logic take_hit;
        logic load_out;
        logic clear_frame;
    } ctl_cmd_t;

    typedef struct packed {
        logic ptr_last;
        logic need_search;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

### sv/ipv4_egress_packet_filter_core.sv
// IPv4 egress packet filter.
// Input channel (s_*): one request per cycle while s_ready is high, a frame
// byte (opcode 0, frame_end on the last byte) or a rule slot write (opcode 1).
// Frame bytes are taken back to back, one per cycle, headers parsed on the fly.
// Result channel (m_*): one drop_frame verdict per frame, after its last byte.
// For short, non-IPv4 or quarantine frames the verdict is latched in the
// DECIDE state and loaded into the output register in PUSH; otherwise a SEARCH
// state between them scans the rule table one slot per cycle (single read port).
// While a verdict is being worked out, s_ready is low.
// Configuration (cfg_*): always ready; index 0 quarantine enable, 1 hub
// address, 2 hub port, 3 DHCP allow, 4 DNS allow; other indexes are ignored.
// Reset: control, config, parser and output-valid registers return to zero,
// then a clearing pass empties the rule table; s_ready stays low during it.
// Receiver stall: the verdict waits in the output register while the next
// frame streams in; a following verdict waits until that register is taken.
module ipv4_egress_packet_filter_core
    import ipv4f_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [7:0]            s_frame_byte,
    input  logic                  s_frame_end,
    input  logic [5:0]            s_slot_index,
    input  logic [31:0]           s_slot_address,
    input  logic [1:0]            s_slot_action,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_drop_frame,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    ipv4f_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_opcode    (s_opcode),
        .s_frame_end (s_frame_end),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    ipv4f_datapath #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_opcode       (s_opcode),
        .s_frame_byte   (s_frame_byte),
        .s_slot_index   (s_slot_index),
        .s_slot_address (s_slot_address),
        .s_slot_action  (s_slot_action),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drop_frame   (m_drop_frame)
    );

endmodule

### sv/ipv4f_ctrl.sv
module ipv4f_ctrl
    import ipv4f_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_opcode,
    input  logic       s_frame_end,
    output logic       s_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.ptr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_opcode == OP_FRAME && s_frame_end) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.latch_verdict = 1'b1;
                if (status.need_search) begin
                    cmd.search_start = 1'b1;
                    state_next       = ST_SEARCH;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_SEARCH: begin
                if (status.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_PUSH;
                end else if (status.ptr_last) begin
                    state_next = ST_PUSH;
                end else begin
                    cmd.search_next = 1'b1;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.load_out    = 1'b1;
                    cmd.clear_frame = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### sv/ipv4f_datapath.sv
module ipv4f_datapath
    import ipv4f_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctl_cmd_t              cmd,
    output dp_status_t            status,
    input  logic                  s_opcode,
    input  logic [7:0]            s_frame_byte,
    input  logic [5:0]            s_slot_index,
    input  logic [31:0]           s_slot_address,
    input  logic [1:0]            s_slot_action,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_drop_frame
);

    localparam int SLOT_AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(RULE_SLOTS - 1);

    logic [31:0] key_mem [RULE_SLOTS];
    logic [1:0]  act_mem [RULE_SLOTS];

    logic        quar_reg;
    logic [31:0] hub_addr_reg;
    logic [15:0] hub_port_reg;
    logic        dhcp_reg;
    logic        dns_reg;

    logic [7:0]  byte_count_reg,  byte_count_next;
    logic [15:0] ether_type_reg,  ether_type_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  protocol_reg,    protocol_next;
    logic [31:0] dest_reg,        dest_next;
    logic [15:0] src_port_reg,    src_port_next;
    logic [15:0] dst_port_reg,    dst_port_next;

    logic [SLOT_AW-1:0] ptr_reg;
    logic [SLOT_AW-1:0] rd_addr;
    logic               rd_en;
    logic [31:0]        rd_key_reg;
    logic [1:0]         rd_act_reg;
    logic               verdict_reg;
    logic               m_valid_reg;
    logic               m_drop_reg;

    logic               wr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic [31:0]        wr_key;
    logic [1:0]         wr_act;

    logic [3:0]  hw_eff;
    logic [7:0]  port_base;
    logic [7:0]  dec_base;
    logic        ports_ok;
    logic [15:0] sp_eff;
    logic [15:0] dp_eff;
    logic        bypass;
    logic        q_pass;
    logic        rule_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quar_reg     <= 1'b0;
            hub_addr_reg <= '0;
            hub_port_reg <= '0;
            dhcp_reg     <= 1'b0;
            dns_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_QUARANTINE: quar_reg     <= cfg_data[0];
                CFG_HUB_ADDR:   hub_addr_reg <= cfg_data[31:0];
                CFG_HUB_PORT:   hub_port_reg <= cfg_data[15:0];
                CFG_DHCP:       dhcp_reg     <= cfg_data[0];
                CFG_DNS:        dns_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        hw_eff    = (byte_count_reg == ETH_HDR_LEN) ? s_frame_byte[3:0] : header_words_reg;
        port_base = ETH_HDR_LEN + {2'b00, hw_eff, 2'b00};

        byte_count_next   = byte_count_reg;
        ether_type_next   = ether_type_reg;
        header_words_next = header_words_reg;
        protocol_next     = protocol_reg;
        dest_next         = dest_reg;
        src_port_next     = src_port_reg;
        dst_port_next     = dst_port_reg;

        if (cmd.accept && s_opcode == OP_FRAME) begin
            case (byte_count_reg)
                8'd12: ether_type_next[15:8] = s_frame_byte;
                8'd13: ether_type_next[7:0]  = s_frame_byte;
                8'd14: header_words_next     = s_frame_byte[3:0];
                8'd23: protocol_next         = s_frame_byte;
                default: ;
            endcase
            if (byte_count_reg >= 8'd30 && byte_count_reg <= 8'd33) begin
                dest_next = {dest_reg[23:0], s_frame_byte};
            end
            if (byte_count_reg == port_base) begin
                src_port_next[15:8] = s_frame_byte;
            end
            if (byte_count_reg == port_base + 8'd1) begin
                src_port_next[7:0] = s_frame_byte;
            end
            if (byte_count_reg == port_base + 8'd2) begin
                dst_port_next[15:8] = s_frame_byte;
            end
            if (byte_count_reg == port_base + 8'd3) begin
                dst_port_next[7:0] = s_frame_byte;
            end
            byte_count_next = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                            : byte_count_reg + 8'd1;
        end

        if (cmd.clear_frame) begin
            byte_count_next   = '0;
            ether_type_next   = '0;
            header_words_next = '0;
            protocol_next     = '0;
            dest_next         = '0;
            src_port_next     = '0;
            dst_port_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            ether_type_reg   <= '0;
            header_words_reg <= '0;
            protocol_reg     <= '0;
            dest_reg         <= '0;
            src_port_reg     <= '0;
            dst_port_reg     <= '0;
        end else begin
            byte_count_reg   <= byte_count_next;
            ether_type_reg   <= ether_type_next;
            header_words_reg <= header_words_next;
            protocol_reg     <= protocol_next;
            dest_reg         <= dest_next;
            src_port_reg     <= src_port_next;
            dst_port_reg     <= dst_port_next;
        end
    end

    always_comb begin
        dec_base = ETH_HDR_LEN + {2'b00, header_words_reg, 2'b00};
        ports_ok = (protocol_reg == PROTO_TCP && byte_count_reg >= dec_base + TCP_HDR_LEN)
                || (protocol_reg == PROTO_UDP && byte_count_reg >= dec_base + UDP_HDR_LEN);
        sp_eff   = ports_ok ? src_port_reg : '0;
        dp_eff   = ports_ok ? dst_port_reg : '0;
        bypass   = (byte_count_reg < MIN_FRAME_LEN) || (ether_type_reg != ETH_TYPE_IPV4);
        q_pass   = (dest_reg[31:24] == LOOPBACK_NET)
                || (hub_addr_reg != '0 && dest_reg == hub_addr_reg
                    && (hub_port_reg == '0 || dp_eff == hub_port_reg
                        || sp_eff == hub_port_reg))
                || (dhcp_reg && protocol_reg == PROTO_UDP
                    && (dp_eff == PORT_DHCP_SRV || dp_eff == PORT_DHCP_CLI))
                || (dns_reg && (dp_eff == PORT_DNS || sp_eff == PORT_DNS));
    end

    assign rule_wr = cmd.accept && s_opcode == OP_RULE
                  && (32'(s_slot_index) < 32'(RULE_SLOTS));

    always_comb begin
        wr_en   = cmd.clear_wr || rule_wr;
        wr_addr = cmd.clear_wr ? ptr_reg : SLOT_AW'(s_slot_index);
        wr_key  = cmd.clear_wr ? '0 : s_slot_address;
        wr_act  = cmd.clear_wr ? ACT_EMPTY : s_slot_action;
        rd_en   = cmd.search_start || cmd.search_next;
        rd_addr = cmd.search_start ? '0 : ptr_reg + SLOT_AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            act_mem[wr_addr] <= wr_act;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_act_reg <= act_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (rd_en) begin
            ptr_reg <= rd_addr;
        end else if (cmd.clear_wr) begin
            ptr_reg <= ptr_reg + SLOT_AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_verdict) begin
            verdict_reg <= !bypass && quar_reg && !q_pass;
        end else if (cmd.take_hit) begin
            verdict_reg <= (rd_act_reg == ACT_BLOCK);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_drop_reg <= verdict_reg;
        end
    end

    assign status.ptr_last    = (ptr_reg == LAST_SLOT);
    assign status.need_search = !bypass && !quar_reg;
    assign status.hit         = (rd_act_reg != ACT_EMPTY) && (rd_key_reg == dest_reg);
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_drop_frame = m_drop_reg;

endmodule
